// ===== src/decimal_seven_segment_led_driver_core_defines.svh =====
// Assertion shorthands for the display driver core.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef DECIMAL_SEVEN_SEGMENT_LED_DRIVER_CORE_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_LED_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication
`define DSSEG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DSSEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsseg_pkg.sv =====
`default_nettype none

package dsseg_pkg;

    localparam int COUNT_W   = 32;
    localparam int LEVEL_W   = 5;
    localparam int VAL_W     = 20;
    localparam int DIGITS    = 6;
    localparam int SEG_W     = 8;
    localparam int SEGS_W    = DIGITS * SEG_W;
    localparam int MASK_W    = 10;
    localparam int LED_COUNT = 10;
    localparam int LVL_SAT_W = 6;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 64;

    localparam logic [VAL_W-1:0] COUNT_MAX = VAL_W'(999999);

    // Reciprocal of ten scaled by 2^23, exact for dividends below 2^22
    localparam int               RECIP_SHIFT = 23;
    localparam logic [VAL_W-1:0] RECIP_TEN   = VAL_W'(20'hCCCCD);

    // Data handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic [VAL_W-1:0]  value;
        logic [SEGS_W-1:0] segs;
        logic [MASK_W-1:0] mask;
    } cell_data_t;

    // Active-high segment pattern, bit 0 is segment a
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // True when the byte is one of the ten digit patterns
    function automatic logic is_seg_code(input logic [SEG_W-1:0] code);
        logic ok;
        case (code)
            8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
            8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F: ok = 1'b1;
            default:                            ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== src/dsseg_front.sv =====
`default_nettype none

module dsseg_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         in_valid,
    input  wire logic signed [dsseg_pkg::COUNT_W-1:0] count_value,
    input  wire logic [dsseg_pkg::LEVEL_W-1:0] level_value,
    output dsseg_pkg::cell_data_t             out_data
);
    import dsseg_pkg::*;

    logic              valid_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [VAL_W-1:0]  value_next;
    logic [MASK_W-1:0] mask_next;
    logic [LVL_SAT_W-1:0] lvl_sat;

    // Clamp the count to the six-digit range
    always_comb
    begin
        if (count_value[COUNT_W-1])
            value_next = '0;
        else if (count_value > COUNT_W'(COUNT_MAX))
            value_next = COUNT_MAX;
        else
            value_next = count_value[VAL_W-1:0];
    end

    // Saturate the level and build the thermometer mask
    always_comb
    begin
        if (LVL_SAT_W'(level_value) > LVL_SAT_W'(LED_COUNT))
            lvl_sat = LVL_SAT_W'(LED_COUNT);
        else
            lvl_sat = LVL_SAT_W'(level_value);
        for (int i = 0; i < MASK_W; i++)
            mask_next[i] = (LVL_SAT_W'(i) < lvl_sat);
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_next;
            mask_reg  <= mask_next;
        end
    end

    assign out_data.valid = valid_reg;
    assign out_data.value = value_reg;
    assign out_data.segs  = '0;
    assign out_data.mask  = mask_reg;

endmodule

`default_nettype wire

// ===== src/dsseg_cell.sv =====
`default_nettype none

module dsseg_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire dsseg_pkg::cell_data_t in_data,
    output dsseg_pkg::cell_data_t out_data
);
    import dsseg_pkg::*;

    logic [2*VAL_W-1:0] product;
    logic [VAL_W-1:0]   quot;
    logic [VAL_W-1:0]   rem;
    logic               valid_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [SEGS_W-1:0]  segs_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [SEGS_W-1:0]  segs_next;

    // Split off the lowest decimal digit by multiplying with the reciprocal
    always_comb
    begin
        product   = (2*VAL_W)'(in_data.value) * (2*VAL_W)'(RECIP_TEN);
        quot      = VAL_W'(product >> RECIP_SHIFT);
        rem       = in_data.value - ((quot << 3) + (quot << 1));
        segs_next = {seg_code(rem[3:0]), in_data.segs[SEGS_W-1:SEG_W]};
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_data.valid;
    end

    // Advance the payload: quotient on, new byte in at the top
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= quot;
            segs_reg  <= segs_next;
            mask_reg  <= in_data.mask;
        end
    end

    assign out_data.valid = valid_reg;
    assign out_data.value = value_reg;
    assign out_data.segs  = segs_reg;
    assign out_data.mask  = mask_reg;

endmodule

`default_nettype wire

// ===== src/decimal_seven_segment_led_driver_core.sv =====
// Each item passes the front register and the six digit cells in turn.
// Throughput: one item per cycle; the front register and six digit cells
// advance together whenever the output register is empty or being taken.
// Reset: rst_n (asynchronous, active low) clears the valid flags of all
// stages; no item is in flight afterwards.
`default_nettype none
`include "decimal_seven_segment_led_driver_core_defines.svh"

module decimal_seven_segment_led_driver_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [31:0] count_value, [36:32] level_value, [39:37] zero
    input  wire logic [dsseg_pkg::IN_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [31:0] digits_low_word, [47:32] digits_high_word, [57:48] led_bar,
    // [63:58] zero
    output logic [dsseg_pkg::OUT_W-1:0]      m_tdata
);
    import dsseg_pkg::*;

    logic       advance;
    cell_data_t chain [DIGITS+1];

    // Move the whole chain when the last cell is empty or being drained
    assign advance  = !chain[DIGITS].valid || m_tready;
    assign s_tready = advance;

    dsseg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .count_value (s_tdata[COUNT_W-1:0]),
        .level_value (s_tdata[COUNT_W+LEVEL_W-1:COUNT_W]),
        .out_data    (chain[0])
    );

    for (genvar g = 0; g < DIGITS; g++)
    begin : g_cell
        dsseg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_data  (chain[g]),
            .out_data (chain[g+1])
        );
    end

    // Drive the master side from the last cell
    assign m_tvalid = chain[DIGITS].valid;
    assign m_tdata  = {(OUT_W-SEGS_W-MASK_W)'(0), chain[DIGITS].mask, chain[DIGITS].segs};

    `DSSEG_ASSERT_SAME(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready),
        "ready does not follow output register state")
    `DSSEG_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, chain[0].valid,
        "accepted transfer did not enter the front stage")
    `DSSEG_ASSERT_SAME(a_value_spent, m_tvalid, chain[DIGITS].value == '0,
        "count left over after six digits")
    `DSSEG_ASSERT_SAME(a_mask_thermo, m_tvalid,
        ((m_tdata[57:48] & (m_tdata[57:48] + 10'd1)) == '0) &&
        ($countones(m_tdata[57:48]) <= LED_COUNT),
        "LED mask is not a saturated thermometer code")
    `DSSEG_ASSERT_SAME(a_seg_codes, m_tvalid,
        is_seg_code(m_tdata[7:0]) && is_seg_code(m_tdata[15:8]) &&
        is_seg_code(m_tdata[23:16]) && is_seg_code(m_tdata[31:24]) &&
        is_seg_code(m_tdata[39:32]) && is_seg_code(m_tdata[47:40]),
        "segment byte is not a digit pattern")

endmodule

`default_nettype wire

// ===== sim/tb_decimal_seven_segment_led_driver_core.sv =====
`timescale 1ns / 1ps

module tb_decimal_seven_segment_led_driver_core;

    import dsseg_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 900;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_CYCLES = 2000;

    // Active-high glyphs, bit 0 is segment a
    localparam logic [7:0] SEGMENT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [LEVEL_W-1:0] level_value;
    } display_item_t;

    typedef struct packed {
        logic [31:0]       digits_low_word;
        logic [15:0]       digits_high_word;
        logic [MASK_W-1:0] led_bar;
    } display_result_t;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_HALF,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    display_item_t       display_items_q [$];
    display_result_t     expected_displays_q [$];
    int                  error_count = 0;

    int                  burst_left = 1;
    int                  gap_left = 0;
    sink_mode_t          sink_mode = SINK_ALWAYS;
    int                  sink_phase_left = 0;
    int unsigned         sink_cycle = 0;
    int                  idle_cycles = 0;

    decimal_seven_segment_led_driver_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Clamp the count, split it into six digits and build the LED bar
    function automatic display_result_t render_display(input logic [COUNT_W-1:0] count_value,
                                                       input logic [LEVEL_W-1:0] level_value);
        display_result_t r;
        int unsigned     n;
        int unsigned     lvl;
        logic [7:0]      glyph [6];
        logic [63:0]     bar;
        if (count_value[COUNT_W-1])
            n = 0;
        else if (count_value > 32'd999999)
            n = 999999;
        else
            n = count_value;
        for (int i = 0; i < 6; i++)
        begin
            glyph[i] = SEGMENT_GLYPH[n % 10];
            n = n / 10;
        end
        lvl = (level_value > LED_COUNT) ? LED_COUNT : level_value;
        bar = (64'd1 << lvl) - 64'd1;
        r.digits_low_word  = {glyph[3], glyph[2], glyph[1], glyph[0]};
        r.digits_high_word = {glyph[5], glyph[4]};
        r.led_bar          = bar[MASK_W-1:0];
        return r;
    endfunction

    // Mix of in-range, out-of-range, negative and boundary counts
    function automatic logic [COUNT_W-1:0] random_count();
        logic [COUNT_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 999999);
            4:          v = $urandom;
            5:          v = $urandom_range(0, 999);
            6:          v = 32'h8000_0000 | $urandom;
            7:          v = $urandom_range(999990, 1000010);
            8:          v = $urandom_range(0, 20) - 32'd10;
            default:    v = $urandom_range(0, 9) * 111111;
        endcase
        return v;
    endfunction

    function automatic display_item_t make_item(input logic [COUNT_W-1:0] count_value,
                                                input logic [LEVEL_W-1:0] level_value);
        display_item_t it;
        it.count_value = count_value;
        it.level_value = level_value;
        return it;
    endfunction

    // Sender: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                void'(display_items_q.pop_front());
            // hold the current item until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (display_items_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_W - COUNT_W - LEVEL_W){1'b0}},
                                 display_items_q[0].level_value,
                                 display_items_q[0].count_value};
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: run each randomly chosen stall pattern for a random phase length
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sink_phase_left == 0)
            begin
                sink_mode       = sink_mode_t'($urandom_range(0, 3));
                sink_phase_left = $urandom_range(32, 256);
            end
            else
                sink_phase_left--;
            sink_cycle++;
            case (sink_mode)
                SINK_ALWAYS: m_tready <= 1'b1;
                SINK_HALF:   m_tready <= $urandom_range(0, 1);
                SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (sink_cycle % 5) != 0;
            endcase
        end
    end

    // Monitor: check results against the oldest prediction, then record new inputs
    always @(posedge clk)
    begin
        display_result_t got;
        display_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.digits_low_word  = m_tdata[31:0];
                got.digits_high_word = m_tdata[47:32];
                got.led_bar          = m_tdata[48 +: MASK_W];
                if (expected_displays_q.size() == 0)
                begin
                    $error("result %h arrived with nothing outstanding", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_displays_q.pop_front();
                    if (got.digits_low_word !== want.digits_low_word)
                    begin
                        $error("digits_low_word: expected %08h, got %08h",
                               want.digits_low_word, got.digits_low_word);
                        error_count++;
                    end
                    if (got.digits_high_word !== want.digits_high_word)
                    begin
                        $error("digits_high_word: expected %04h, got %04h",
                               want.digits_high_word, got.digits_high_word);
                        error_count++;
                    end
                    if (got.led_bar !== want.led_bar)
                    begin
                        $error("led_bar: expected %03h, got %03h",
                               want.led_bar, got.led_bar);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_displays_q.push_back(render_display(s_tdata[COUNT_W-1:0],
                                                             s_tdata[COUNT_W +: LEVEL_W]));
        end
    end

    // Watchdog: drop out if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed: clamping at both ends, every digit, level saturation
        display_items_q.push_back(make_item(32'd0, 5'd0));
        display_items_q.push_back(make_item(32'd1, 5'd1));
        display_items_q.push_back(make_item(32'hFFFF_FFFF, 5'd31));
        display_items_q.push_back(make_item(32'h8000_0000, 5'd10));
        display_items_q.push_back(make_item(32'h7FFF_FFFF, 5'd11));
        display_items_q.push_back(make_item(32'd999999, 5'd9));
        display_items_q.push_back(make_item(32'd1000000, 5'd5));
        display_items_q.push_back(make_item(32'd999998, 5'd2));
        display_items_q.push_back(make_item(32'd123456, 5'd3));
        display_items_q.push_back(make_item(32'd789012, 5'd4));
        display_items_q.push_back(make_item(32'd345678, 5'd6));
        display_items_q.push_back(make_item(32'd901234, 5'd7));
        display_items_q.push_back(make_item(32'd100000, 5'd8));
        display_items_q.push_back(make_item(32'd10, 5'd12));
        display_items_q.push_back(make_item(32'd9, 5'd16));
        display_items_q.push_back(make_item(-32'sd999999, 5'd31));
        display_items_q.push_back(make_item(32'd1000001, 5'd21));
        display_items_q.push_back(make_item(32'd55555, 5'd30));
        display_items_q.push_back(make_item(32'h5555_5555, 5'd15));
        display_items_q.push_back(make_item(32'hAAAA_AAAA, 5'd26));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            display_items_q.push_back(make_item(random_count(), $urandom_range(0, 31)));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken and every result to come back
        do
            @(negedge clk);
        while (display_items_q.size() != 0 || s_tvalid || expected_displays_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
